### src/glpf_pkg.sv
// Package for the grid local peak finder.
// Holds sizes, register indexes and the queue entry type; no dependencies.
package glpf_pkg;

    localparam int MAX_COLS    = 32;
    localparam int MAX_ROWS    = 1024;
    localparam int SAMPLE_BITS = 16;

    localparam int COL_BITS   = $clog2(MAX_COLS);
    localparam int ROW_BITS   = $clog2(MAX_ROWS);
    localparam int CFG_ROWS_W = 11;
    localparam int CFG_COLS_W = 6;
    localparam int CFG_DATA_W = 11;
    localparam int CFG_IDX_W  = 2;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLS = CFG_IDX_W'(1);

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic [ROW_BITS-1:0]           row;
        logic [COL_BITS-1:0]           col;
        logic                          last_smp;
    } t_item;

endpackage

### src/glpf_in_if.sv
// Input channel interface: one grid sample per beat.
// Depends on glpf_pkg.
interface glpf_in_if import glpf_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_value;

    modport source (output valid, output sample_value, input ready);
    modport sink (input valid, input sample_value, output ready);
endinterface

### src/glpf_out_if.sv
// Output channel interface: one peak coordinate per beat.
// Depends on glpf_pkg.
interface glpf_out_if import glpf_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [ROW_BITS-1:0] peak_row;
    logic [COL_BITS-1:0] peak_col;
    logic                last_of_run;

    modport source (output valid, output peak_row, output peak_col, output last_of_run,
                    input ready);
    modport sink (input valid, input peak_row, input peak_col, input last_of_run,
                  output ready);
endinterface

### src/glpf_front.sv
// Front end: accepts samples, tracks the raster position and holds the grid size.
// Depends on glpf_pkg and glpf_in_if.
module glpf_front import glpf_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    glpf_in_if.sink               i_in,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_full,
    output logic                  o_push,
    output t_item                 o_item,
    output logic [COL_BITS-1:0]   o_cols_m1
);

    logic [ROW_BITS-1:0]   r_rows_m1;
    logic [COL_BITS-1:0]   r_cols_m1;
    logic [ROW_BITS-1:0]   r_row;
    logic [COL_BITS-1:0]   r_col;
    logic [ROW_BITS-1:0]   n_rows_m1;
    logic [COL_BITS-1:0]   n_cols_m1;
    logic [CFG_ROWS_W-1:0] rows_val;
    logic [CFG_COLS_W-1:0] cols_val;
    logic                  last_col;
    logic                  last_smp;

    assign i_in.ready = !i_full;
    assign o_push     = i_in.valid && !i_full;
    assign last_col   = (r_col == r_cols_m1);
    assign last_smp   = last_col && (r_row == r_rows_m1);
    assign o_cols_m1  = r_cols_m1;

    assign o_item.sample   = i_in.sample_value;
    assign o_item.row      = r_row;
    assign o_item.col      = r_col;
    assign o_item.last_smp = last_smp;

    always_comb begin
        rows_val = i_cfg_data[CFG_ROWS_W-1:0];
        cols_val = i_cfg_data[CFG_COLS_W-1:0];
        if (rows_val == '0) begin
            n_rows_m1 = '0;
        end else if (rows_val > CFG_ROWS_W'(MAX_ROWS)) begin
            n_rows_m1 = ROW_BITS'(MAX_ROWS - 1);
        end else begin
            n_rows_m1 = ROW_BITS'(rows_val - CFG_ROWS_W'(1));
        end
        if (cols_val == '0) begin
            n_cols_m1 = '0;
        end else if (cols_val > CFG_COLS_W'(MAX_COLS)) begin
            n_cols_m1 = COL_BITS'(MAX_COLS - 1);
        end else begin
            n_cols_m1 = COL_BITS'(cols_val - CFG_COLS_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_m1 <= '0;
            r_cols_m1 <= '0;
            r_row     <= '0;
            r_col     <= '0;
        end else if (i_cfg_we && (i_cfg_idx == CFG_NUM_ROWS || i_cfg_idx == CFG_NUM_COLS)) begin
            if (i_cfg_idx == CFG_NUM_ROWS) begin
                r_rows_m1 <= n_rows_m1;
            end else begin
                r_cols_m1 <= n_cols_m1;
            end
            r_row <= '0;
            r_col <= '0;
        end else if (o_push) begin
            if (last_smp) begin
                r_row <= '0;
                r_col <= '0;
            end else if (last_col) begin
                r_row <= r_row + ROW_BITS'(1);
                r_col <= '0;
            end else begin
                r_col <= r_col + COL_BITS'(1);
            end
        end
    end

endmodule

### src/glpf_fifo.sv
// Short queue of samples, tagged with their grid positions, between the front and back ends.
// Depends on glpf_pkg.
module glpf_fifo import glpf_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_item o_head
);

    t_item                 r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr_ptr;
    logic [FIFO_PTR_W-1:0] r_rd_ptr;
    logic [FIFO_PTR_W:0]   r_count;

    assign o_full  = (r_count == (FIFO_PTR_W+1)'(FIFO_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + FIFO_PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (FIFO_PTR_W+1)'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - (FIFO_PTR_W+1)'(1);
            end
        end
    end

endmodule

### src/glpf_back.sv
// Back end: row stores, neighbour reads, peak decisions and the result register.
// Depends on glpf_pkg and glpf_out_if.
module glpf_back import glpf_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  t_item               i_item,
    output logic                o_pop,
    input  logic [COL_BITS-1:0] i_cols_m1,
    glpf_out_if.source          o_out
);

    typedef enum logic [2:0] {
        S_IDLE, S_P0, S_P1, S_P2, S_P3, S_WRITE, S_END
    } t_state;

    logic signed [SAMPLE_BITS-1:0] r_older [MAX_COLS];
    logic signed [SAMPLE_BITS-1:0] r_newer [MAX_COLS];
    logic signed [SAMPLE_BITS-1:0] r_old_q;
    logic signed [SAMPLE_BITS-1:0] r_new_q;

    t_state                        r_state;
    logic signed [SAMPLE_BITS-1:0] r_s;
    logic [ROW_BITS-1:0]           r_row;
    logic [COL_BITS-1:0]           r_col;
    logic                          r_last;
    logic [COL_BITS-1:0]           r_k;
    logic                          r_flush;
    logic signed [SAMPLE_BITS-1:0] r_ctr;
    logic signed [SAMPLE_BITS-1:0] r_up;
    logic signed [SAMPLE_BITS-1:0] r_right;
    logic signed [SAMPLE_BITS-1:0] r_lft;
    logic                          r_pend_v;
    logic [ROW_BITS-1:0]           r_pend_row;
    logic [COL_BITS-1:0]           r_pend_col;
    logic                          r_out_v;
    logic [ROW_BITS-1:0]           r_out_row;
    logic [COL_BITS-1:0]           r_out_col;
    logic                          r_out_last;

    logic [COL_BITS-1:0] old_addr;
    logic [COL_BITS-1:0] new_addr;
    logic                wr_en;
    logic                slot_free;
    logic                first_k;
    logic                last_k;
    logic                pk_norm;
    logic                pk_flush;
    logic                pk;
    logic                can_go;
    logic                push_mid;
    logic                push_end;
    logic [ROW_BITS-1:0] pk_row;

    assign o_out.valid       = r_out_v;
    assign o_out.peak_row    = r_out_row;
    assign o_out.peak_col    = r_out_col;
    assign o_out.last_of_run = r_out_last;

    assign o_pop     = (r_state == S_IDLE) && i_valid;
    assign wr_en     = (r_state == S_WRITE);
    assign slot_free = !r_out_v || o_out.ready;
    assign first_k   = (r_k == '0);
    assign last_k    = (r_k == i_cols_m1);

    always_comb begin
        old_addr = r_k;
        new_addr = r_k;
        unique case (r_state)
            S_P1: begin
                old_addr = r_k - COL_BITS'(1);
                new_addr = r_k + COL_BITS'(1);
            end
            S_P2, S_P3: begin
                new_addr = r_k - COL_BITS'(1);
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        pk_norm = (r_ctr >= r_s)
            && !((r_row > ROW_BITS'(1)) && (r_ctr < r_up))
            && !(!first_k && (r_ctr < r_lft))
            && !(!last_k && (r_ctr < r_right));
        pk_flush = !((r_row != '0) && (r_ctr < r_up))
            && !(!first_k && (r_ctr < r_new_q))
            && !(!last_k && (r_ctr < r_right));
        pk       = r_flush ? pk_flush : pk_norm;
        pk_row   = r_flush ? r_row : r_row - ROW_BITS'(1);
        can_go   = !pk || !r_pend_v || slot_free;
        push_mid = (r_state == S_P3) && pk && r_pend_v && slot_free;
        push_end = (r_state == S_END) && r_pend_v && slot_free;
    end

    always_ff @(posedge i_clk) begin
        r_old_q <= r_older[old_addr];
        r_new_q <= r_newer[new_addr];
        if (wr_en) begin
            r_older[r_col] <= r_ctr;
            r_newer[r_col] <= r_s;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
            r_flush  <= 1'b0;
        end else begin
            if (push_mid || push_end) begin
                r_out_v    <= 1'b1;
                r_out_row  <= r_pend_row;
                r_out_col  <= r_pend_col;
                r_out_last <= push_end;
            end else if (o_out.ready) begin
                r_out_v <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_s     <= i_item.sample;
                        r_row   <= i_item.row;
                        r_col   <= i_item.col;
                        r_k     <= i_item.col;
                        r_last  <= i_item.last_smp;
                        r_flush <= 1'b0;
                        r_state <= (i_item.row == '0) ? S_WRITE : S_P0;
                    end
                end
                S_P0: begin
                    r_state <= S_P1;
                end
                S_P1: begin
                    r_ctr   <= r_new_q;
                    r_up    <= r_old_q;
                    r_state <= S_P2;
                end
                S_P2: begin
                    r_right <= r_new_q;
                    r_lft   <= r_old_q;
                    r_state <= S_P3;
                end
                S_P3: begin
                    if (can_go) begin
                        if (pk) begin
                            r_pend_v   <= 1'b1;
                            r_pend_row <= pk_row;
                            r_pend_col <= r_k;
                        end
                        if (!r_flush) begin
                            r_state <= S_WRITE;
                        end else if (last_k) begin
                            r_state <= S_END;
                        end else begin
                            r_k     <= r_k + COL_BITS'(1);
                            r_state <= S_P0;
                        end
                    end
                end
                S_WRITE: begin
                    if (r_last) begin
                        r_k     <= '0;
                        r_flush <= 1'b1;
                        r_state <= S_P0;
                    end else begin
                        r_state <= S_END;
                    end
                end
                S_END: begin
                    if (!r_pend_v) begin
                        r_state <= S_IDLE;
                    end else if (slot_free) begin
                        r_pend_v <= 1'b0;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

### src/grid_local_peak_finder_top.sv
// Top level of the grid local peak finder: front end, queue and back end.
// Depends on glpf_pkg, glpf_in_if, glpf_out_if, glpf_front, glpf_fifo and glpf_back.
// A first-row sample passes the back end's idle, write and end states; later rows add the read
// states P0 to P3 first, as neighbour reads use the single read port of each row store. The last
// sample of a grid adds a flush of the final row: the read states per column, then the end state.
// A peak decision is held pending until the next peak or the end of the run, then registered.
// Reset is synchronous and active low; it empties the queue and the result register, returns the
// grid to one by one and the position to the origin, and leaves the row stores unset.
module grid_local_peak_finder_top import glpf_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    glpf_in_if.sink               i_in,
    glpf_out_if.source            o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic                push;
    logic                full;
    t_item               front_item;
    logic [COL_BITS-1:0] cols_m1;
    logic                q_valid;
    logic                q_pop;
    t_item               q_head;

    glpf_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_full     (full),
        .o_push     (push),
        .o_item     (front_item),
        .o_cols_m1  (cols_m1)
    );

    glpf_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_head  (q_head)
    );

    glpf_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (q_valid),
        .i_item    (q_head),
        .o_pop     (q_pop),
        .i_cols_m1 (cols_m1),
        .o_out     (o_out)
    );

endmodule

### verif/tb_grid_local_peak_finder_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for grid_local_peak_finder_top: streams sample grids and predicts peaks.
// Depends on glpf_pkg, glpf_in_if, glpf_out_if and the block's RTL.
module tb_grid_local_peak_finder_top;
    import glpf_pkg::*;

    localparam int SETTLE_CYCLES  = 300;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_ITEMS   = 180;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_A = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_B = CFG_IDX_W'(3);

    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

    typedef enum int {SPREAD_TIGHT, SPREAD_MID, SPREAD_FULL} t_spread;

    typedef struct packed {
        logic [ROW_BITS-1:0] row;
        logic [COL_BITS-1:0] col;
        logic                last_of_run;
    } t_peak_coord;

    class t_peak_scoreboard;
        logic signed [SAMPLE_BITS-1:0] older_line [MAX_COLS];
        logic signed [SAMPLE_BITS-1:0] newer_line [MAX_COLS];
        int                            next_row;
        int                            next_col;
        logic [CFG_ROWS_W-1:0]         rows_reg;
        logic [CFG_COLS_W-1:0]         cols_reg;
        t_peak_coord                   awaited [$];
        int unsigned                   faults;

        function new();
            foreach (older_line[k]) begin
                older_line[k] = '0;
                newer_line[k] = '0;
            end
            next_row = 0;
            next_col = 0;
            rows_reg = CFG_ROWS_W'(1);
            cols_reg = CFG_COLS_W'(1);
            faults   = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_NUM_ROWS) begin
                rows_reg = data[CFG_ROWS_W-1:0];
            end else if (idx == CFG_NUM_COLS) begin
                cols_reg = data[CFG_COLS_W-1:0];
            end else begin
                return;
            end
            next_row = 0;
            next_col = 0;
        endfunction

        function int grid_rows();
            if (rows_reg == 0) return 1;
            if (rows_reg > MAX_ROWS) return MAX_ROWS;
            return int'(rows_reg);
        endfunction

        function int grid_cols();
            if (cols_reg == 0) return 1;
            if (cols_reg > MAX_COLS) return MAX_COLS;
            return int'(cols_reg);
        endfunction

        // The sample above the new one is decided now; the last sample also decides the bottom row.
        function void note_sample(logic signed [SAMPLE_BITS-1:0] s);
            int                            rows;
            int                            cols;
            int                            r;
            int                            c;
            int                            k;
            logic signed [SAMPLE_BITS-1:0] ctr;
            bit                            pk;
            t_peak_coord                   run [$];
            rows = grid_rows();
            cols = grid_cols();
            r = next_row;
            c = next_col;
            if (r > 0) begin
                ctr = newer_line[c];
                pk = (ctr >= s);
                if (r > 1 && ctr < older_line[c]) pk = 1'b0;
                if (c > 0 && ctr < older_line[c-1]) pk = 1'b0;
                if (c + 1 < cols && ctr < newer_line[c+1]) pk = 1'b0;
                if (pk) run.push_back('{ROW_BITS'(r - 1), COL_BITS'(c), 1'b0});
            end
            older_line[c] = newer_line[c];
            newer_line[c] = s;
            if (r + 1 == rows && c + 1 == cols) begin
                for (k = 0; k < cols; k++) begin
                    ctr = newer_line[k];
                    pk = 1'b1;
                    if (r > 0 && ctr < older_line[k]) pk = 1'b0;
                    if (k > 0 && ctr < newer_line[k-1]) pk = 1'b0;
                    if (k + 1 < cols && ctr < newer_line[k+1]) pk = 1'b0;
                    if (pk) run.push_back('{ROW_BITS'(r), COL_BITS'(k), 1'b0});
                end
                next_row = 0;
                next_col = 0;
            end else if (c + 1 == cols) begin
                next_col = 0;
                next_row = r + 1;
            end else begin
                next_col = c + 1;
            end
            if (run.size() > 0) run[run.size()-1].last_of_run = 1'b1;
            foreach (run[i]) awaited.push_back(run[i]);
        endfunction

        function void check_peak(logic [ROW_BITS-1:0] row, logic [COL_BITS-1:0] col,
                                 logic last_of_run);
            t_peak_coord want;
            if (awaited.size() == 0) begin
                $error("unexpected peak beat: row %0d col %0d last %0d", row, col, last_of_run);
                faults++;
                return;
            end
            want = awaited.pop_front();
            if (row !== want.row) begin
                $error("peak_row: expected %0d, actual %0d", want.row, row);
                faults++;
            end
            if (col !== want.col) begin
                $error("peak_col: expected %0d, actual %0d", want.col, col);
                faults++;
            end
            if (last_of_run !== want.last_of_run) begin
                $error("last_of_run: expected %0d, actual %0d", want.last_of_run, last_of_run);
                faults++;
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    bit                    no_gaps = 1'b0;
    bit                    hold_req = 1'b0;

    t_peak_scoreboard sb = new();

    glpf_in_if  in_ch ();
    glpf_out_if out_ch ();

    grid_local_peak_finder_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always #4 i_clk = ~i_clk;

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (no_gaps) return 0;
        if (roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] draw_sample(t_spread sp);
        int roll;
        roll = $urandom_range(0, 15);
        if (sp == SPREAD_TIGHT) return SAMPLE_BITS'(int'($urandom_range(0, 3)) - 2);
        if (sp == SPREAD_MID) return SAMPLE_BITS'(int'($urandom_range(0, 15)) - 8);
        if (roll == 0) return SAMPLE_MIN;
        if (roll == 1) return SAMPLE_MAX;
        return SAMPLE_BITS'($urandom());
    endfunction

    task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] v);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.sample_value <= v;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_sample(v);
    endtask

    task automatic drain();
        do @(posedge i_clk); while (sb.awaited.size() != 0);
    endtask

    task automatic settle();
        in_ch.valid <= 1'b0;
        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] rows_d,
                             input logic [CFG_DATA_W-1:0] cols_d);
        settle();
        if ($urandom_range(0, 4) == 0) begin
            cfg_write(($urandom_range(0, 1) == 0) ? CFG_UNUSED_A : CFG_UNUSED_B,
                      CFG_DATA_W'($urandom()));
        end
        cfg_write(CFG_NUM_ROWS, rows_d);
        cfg_write(CFG_NUM_COLS, cols_d);
    endtask

    // Result side: checks each beat and stalls at random, or for a long hold-off on request.
    initial begin
        int stall_left;
        int hold_left;
        bit hold_done;
        stall_left = 0;
        hold_left  = 0;
        hold_done  = 1'b0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_ch.valid && out_ch.ready) begin
                sb.check_peak(out_ch.peak_row, out_ch.peak_col, out_ch.last_of_run);
            end
            if (hold_req && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
            end else if (stall_left > 0) begin
                stall_left--;
            end else if ($urandom_range(0, 3) == 0) begin
                stall_left = pick_gap();
            end
            out_ch.ready <= (hold_left == 0 && stall_left == 0);
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("tb_grid_local_peak_finder_top NOT OK");
        $finish;
    end

    initial begin
        int                    random_items;
        int                    phase;
        int                    roll;
        int                    rows_n;
        int                    cols_n;
        int                    cols_f;
        int                    n;
        int                    i;
        logic [CFG_DATA_W-1:0] rows_d;
        logic [CFG_DATA_W-1:0] cols_d;
        t_spread               sp;
        random_items = 0;
        phase        = 0;
        i_rst_n            <= 1'b0;
        in_ch.valid        <= 1'b0;
        in_ch.sample_value <= '0;
        cfg_we             <= 1'b0;
        cfg_idx            <= CFG_NUM_ROWS;
        cfg_data           <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset size is one by one, so every sample is a peak on its own.
        send_sample(SAMPLE_MIN);
        send_sample(SAMPLE_MAX);
        configure('0, '0);
        send_sample('0);

        // A flat grid makes every sample a peak; writes to unused indexes must not restart it.
        configure(CFG_DATA_W'(3), CFG_DATA_W'(3));
        repeat (4) send_sample(SAMPLE_BITS'(-1));
        settle();
        cfg_write(CFG_UNUSED_A, '1);
        cfg_write(CFG_UNUSED_B, '1);
        repeat (5) send_sample(SAMPLE_BITS'(-1));

        configure(CFG_DATA_W'(1), CFG_DATA_W'(5));
        send_sample(SAMPLE_BITS'(1));
        send_sample(SAMPLE_BITS'(3));
        send_sample(SAMPLE_BITS'(2));
        send_sample(SAMPLE_BITS'(2));
        send_sample(SAMPLE_MIN);

        configure(CFG_DATA_W'(4), CFG_DATA_W'(1));
        send_sample(SAMPLE_BITS'(5));
        send_sample(SAMPLE_BITS'(5));
        send_sample(SAMPLE_BITS'(7));
        send_sample(SAMPLE_BITS'(-3));

        // The result side holds off while samples keep coming, so the block backs up.
        configure(CFG_DATA_W'(4), CFG_DATA_W'(8));
        no_gaps  <= 1'b1;
        hold_req <= 1'b1;
        repeat (32) send_sample(draw_sample(SPREAD_TIGHT));

        while (random_items < RANDOM_ITEMS) begin
            roll = $urandom_range(0, 9);
            if (roll == 0) begin
                cols_n = MAX_COLS;
                cols_f = $urandom_range(MAX_COLS, 63);
                rows_n = $urandom_range(1, 2);
            end else if (roll == 1) begin
                cols_n = 1;
                cols_f = 0;
                rows_n = $urandom_range(1, 6);
            end else begin
                cols_n = $urandom_range(1, 8);
                cols_f = cols_n;
                rows_n = $urandom_range(1, 6);
            end
            rows_d = (rows_n == 1 && $urandom_range(0, 1) == 0) ? '0 : CFG_DATA_W'(rows_n);
            cols_d = {5'($urandom()), 6'(cols_f)};
            n = rows_n * cols_n * $urandom_range(1, 2);
            if ($urandom_range(0, 3) == 0) n = $urandom_range(1, n);
            sp = t_spread'($urandom_range(0, 2));
            configure(rows_d, cols_d);
            no_gaps <= ($urandom_range(0, 3) == 0);
            for (i = 0; i < n; i++) begin
                if (phase == 2 && i == n / 2) begin
                    in_ch.valid <= 1'b0;
                    drain();
                end
                send_sample(draw_sample(sp));
            end
            random_items += n;
            phase++;
        end

        // Largest settings: a partial wide grid, an oversized row count and an oversized column count.
        configure(CFG_DATA_W'(MAX_ROWS), CFG_DATA_W'(MAX_COLS));
        no_gaps <= 1'b0;
        repeat (48) send_sample(draw_sample(SPREAD_FULL));
        configure('1, CFG_DATA_W'(1));
        repeat (16) send_sample(draw_sample(SPREAD_TIGHT));
        configure(CFG_DATA_W'(2), '1);
        repeat (2 * MAX_COLS) send_sample(draw_sample(SPREAD_MID));

        settle();
        if (sb.faults == 0) begin
            $display("tb_grid_local_peak_finder_top OK");
        end else begin
            $display("tb_grid_local_peak_finder_top NOT OK");
        end
        $finish;
    end

endmodule
